FILE: rtl/utf8_stream_decoder_unit_defines.svh
// Assertion macros shared by the UTF-8 stream decoder RTL.
// Needs signals named clock and reset in the module that uses them.
`ifndef UTF8_STREAM_DECODER_UNIT_DEFINES_SVH
`define UTF8_STREAM_DECODER_UNIT_DEFINES_SVH

`ifndef SYNTH
`define UTF8SD_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);
`define UTF8SD_ASSERT_NEVER(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) !(cond)) \
      else $error(msg);
`else
`define UTF8SD_ASSERT(label, prop, msg)
`define UTF8SD_ASSERT_NEVER(label, cond, msg)
`endif

`endif

FILE: rtl/utf8sd_pkg.sv
// Types and constants of the UTF-8 stream decoder.
// No dependencies; every other file but the assertion macros header imports it.
`default_nettype none

package utf8sd_pkg;

   localparam int CP_W      = 31;
   localparam int LEN_W     = 3;
   localparam int BYTE_W    = 8;
   localparam int PAYLOAD_W = 7;
   localparam int CONT_W    = 6;
   localparam int KIND_W    = 2;

   localparam logic [KIND_W-1:0] KIND_ASCII   = 2'd0;
   localparam logic [KIND_W-1:0] KIND_CONT    = 2'd1;
   localparam logic [KIND_W-1:0] KIND_LEAD    = 2'd2;
   localparam logic [KIND_W-1:0] KIND_INVALID = 2'd3;

   localparam logic [LEN_W-1:0] LEN_ASCII = 3'd1;

   typedef struct packed {
      logic [KIND_W-1:0]    kind;
      logic [LEN_W-1:0]     len;
      logic [PAYLOAD_W-1:0] payload;
      logic                 last;
   } utf8sd_entry_type;

   typedef struct packed {
      logic             valid;
      utf8sd_entry_type entry;
   } utf8sd_push_type;

endpackage

`default_nettype wire

FILE: rtl/utf8sd_req_if.sv
// Request channel of the UTF-8 stream decoder: one byte per request.
// Depends on utf8sd_pkg for the field widths.
`default_nettype none

interface utf8sd_req_if;
   import utf8sd_pkg::*;

   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] byte_in;
   logic              end_of_text;

   modport source (output valid, output byte_in, output end_of_text, input ready);
   modport sink (input valid, input byte_in, input end_of_text, output ready);
endinterface

`default_nettype wire

FILE: rtl/utf8sd_rsp_if.sv
// Result channel of the UTF-8 stream decoder: one decoded character or error.
// Depends on utf8sd_pkg for the field widths.
`default_nettype none

interface utf8sd_rsp_if;
   import utf8sd_pkg::*;

   logic             valid;
   logic             ready;
   logic [CP_W-1:0]  code_point;
   logic [LEN_W-1:0] seq_length;
   logic             error;

   modport source (output valid, output code_point, output seq_length, output error,
                   input ready);
   modport sink (input valid, input code_point, input seq_length, input error,
                 output ready);
endinterface

`default_nettype wire

FILE: rtl/utf8_stream_decoder_unit.sv
// UTF-8 stream decoder, top level.
//
// Requests on req_bus carry one byte of text each, with end_of_text set on the
// final byte. Bytes in the original one to six byte forms are decoded into
// code points of up to 31 bits. Each completed character gives one result on
// rsp_bus with its code point and length; a lone continuation byte, an FE or
// FF lead, a foreign byte inside a sequence or text ending mid-sequence gives
// one result with error set, and the partial sequence is dropped.
// One request is taken per cycle while the queue is not full. Each accepted
// request is queued; the single decode step, which sets the rate, takes its
// byte from the queue head when the result register is empty or being read.
// When the receiver stalls, the result register holds its contents and up to
// QUEUE_DEPTH further requests are queued before req_bus.ready falls.
// Synchronous reset empties the queue, returns the decoder to idle and
// withdraws any pending result.
`default_nettype none

module utf8_stream_decoder_unit #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic         clock,
   input  logic         reset,
   utf8sd_req_if.sink   req_bus,
   utf8sd_rsp_if.source rsp_bus
);
   import utf8sd_pkg::*;

   utf8sd_push_type push;
   utf8sd_push_type head;
   logic            queue_full;
   logic            pop;

   utf8sd_front u_front (
      .req_bus    (req_bus),
      .queue_full (queue_full),
      .push       (push)
   );

   utf8sd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .full  (queue_full),
      .head  (head),
      .pop   (pop)
   );

   utf8sd_back u_back (
      .clock   (clock),
      .reset   (reset),
      .head    (head),
      .pop     (pop),
      .rsp_bus (rsp_bus)
   );

endmodule

`default_nettype wire

FILE: rtl/utf8sd_front.sv
// Front end: accepts request bytes and classifies them for the decode queue.
// Depends on utf8sd_pkg and utf8sd_req_if.
`default_nettype none

module utf8sd_front (
   utf8sd_req_if.sink             req_bus,
   input  logic                   queue_full,
   output utf8sd_pkg::utf8sd_push_type push
);
   import utf8sd_pkg::*;

   logic [BYTE_W-1:0] b;

   assign b = req_bus.byte_in;
   assign req_bus.ready = !queue_full;

   always_comb begin
      push.valid = req_bus.valid && !queue_full;
      push.entry.last = req_bus.end_of_text;
      push.entry.kind = KIND_INVALID;
      push.entry.len = '0;
      push.entry.payload = '0;
      case (b) inside
         [8'h00:8'h7F]: begin
            push.entry.kind = KIND_ASCII;
            push.entry.len = LEN_ASCII;
            push.entry.payload = b[PAYLOAD_W-1:0];
         end
         [8'h80:8'hBF]: begin
            push.entry.kind = KIND_CONT;
            push.entry.payload = PAYLOAD_W'(b & 8'h3F);
         end
         [8'hC0:8'hDF]: begin
            push.entry.kind = KIND_LEAD;
            push.entry.len = LEN_W'(2);
            push.entry.payload = PAYLOAD_W'(b & 8'h1F);
         end
         [8'hE0:8'hEF]: begin
            push.entry.kind = KIND_LEAD;
            push.entry.len = LEN_W'(3);
            push.entry.payload = PAYLOAD_W'(b & 8'h0F);
         end
         [8'hF0:8'hF7]: begin
            push.entry.kind = KIND_LEAD;
            push.entry.len = LEN_W'(4);
            push.entry.payload = PAYLOAD_W'(b & 8'h07);
         end
         [8'hF8:8'hFB]: begin
            push.entry.kind = KIND_LEAD;
            push.entry.len = LEN_W'(5);
            push.entry.payload = PAYLOAD_W'(b & 8'h03);
         end
         [8'hFC:8'hFD]: begin
            push.entry.kind = KIND_LEAD;
            push.entry.len = LEN_W'(6);
            push.entry.payload = PAYLOAD_W'(b & 8'h01);
         end
         default: begin
            push.entry.kind = KIND_INVALID;
         end
      endcase
   end

endmodule

`default_nettype wire

FILE: rtl/utf8sd_queue.sv
// Short queue of classified bytes between the front end and the decoder.
// Depends on utf8sd_pkg and the assertion macros header.
`default_nettype none
`include "utf8_stream_decoder_unit_defines.svh"

module utf8sd_queue #(
   parameter int DEPTH = 4
) (
   input  logic                        clock,
   input  logic                        reset,
   input  utf8sd_pkg::utf8sd_push_type push,
   output logic                        full,
   output utf8sd_pkg::utf8sd_push_type head,
   input  logic                        pop
);
   import utf8sd_pkg::*;

   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   utf8sd_entry_type entries_ff [DEPTH];
   logic [IDX_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [IDX_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             pop_ok;

   assign full = (count_ff == CNT_W'(DEPTH));
   assign head.valid = (count_ff != '0);
   assign head.entry = entries_ff[rd_ptr_ff];
   assign pop_ok = pop && head.valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push.valid) begin
         wr_ptr_in = (wr_ptr_ff == IDX_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop_ok) begin
         rd_ptr_in = (rd_ptr_ff == IDX_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      count_in = count_ff + CNT_W'(push.valid) - CNT_W'(pop_ok);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.valid) begin
         entries_ff[wr_ptr_ff] <= push.entry;
      end
   end

   `UTF8SD_ASSERT_NEVER(a_count_bound, count_ff > CNT_W'(DEPTH), "queue count exceeds depth")
   `UTF8SD_ASSERT(a_count_track, 1'b1 |=> count_ff == $past(count_ff + CNT_W'(push.valid) - CNT_W'(pop && count_ff != '0)), "queue count lost a request")

endmodule

`default_nettype wire

FILE: rtl/utf8sd_back.sv
// Back end: runs the sequence decoder on queued bytes and holds the result register.
// Depends on utf8sd_pkg, utf8sd_rsp_if and the assertion macros header.
`default_nettype none
`include "utf8_stream_decoder_unit_defines.svh"

module utf8sd_back (
   input  logic                        clock,
   input  logic                        reset,
   input  utf8sd_pkg::utf8sd_push_type head,
   output logic                        pop,
   utf8sd_rsp_if.source                rsp_bus
);
   import utf8sd_pkg::*;

   logic [LEN_W-1:0] pend_ff, pend_in;
   logic [LEN_W-1:0] total_ff, total_in;
   logic [CP_W-1:0]  accum_ff, accum_in;
   logic             o_valid_ff, o_valid_in;
   logic [CP_W-1:0]  o_cp_ff, o_cp_in;
   logic [LEN_W-1:0] o_len_ff, o_len_in;
   logic             o_err_ff, o_err_in;
   logic             emit;
   logic [CP_W-1:0]  acc_next;
   logic [LEN_W-1:0] pend_next;

   assign pop = head.valid && (!o_valid_ff || rsp_bus.ready);
   assign acc_next = CP_W'({accum_ff, head.entry.payload[CONT_W-1:0]});
   assign pend_next = pend_ff - 1'b1;

   always_comb begin
      pend_in = pend_ff;
      total_in = total_ff;
      accum_in = accum_ff;
      emit = 1'b0;
      o_cp_in = o_cp_ff;
      o_len_in = o_len_ff;
      o_err_in = o_err_ff;
      if (pop) begin
         if (pend_ff == '0) begin
            case (head.entry.kind)
               KIND_ASCII: begin
                  emit = 1'b1;
                  o_cp_in = CP_W'(head.entry.payload);
                  o_len_in = LEN_ASCII;
                  o_err_in = 1'b0;
               end
               KIND_LEAD: begin
                  if (head.entry.last) begin
                     emit = 1'b1;
                     o_cp_in = '0;
                     o_len_in = '0;
                     o_err_in = 1'b1;
                  end else begin
                     pend_in = head.entry.len - 1'b1;
                     total_in = head.entry.len;
                     accum_in = CP_W'(head.entry.payload);
                  end
               end
               default: begin
                  emit = 1'b1;
                  o_cp_in = '0;
                  o_len_in = '0;
                  o_err_in = 1'b1;
               end
            endcase
         end else if (head.entry.kind != KIND_CONT) begin
            emit = 1'b1;
            o_cp_in = '0;
            o_len_in = '0;
            o_err_in = 1'b1;
            pend_in = '0;
            total_in = '0;
            accum_in = '0;
         end else if (pend_next == '0) begin
            emit = 1'b1;
            o_cp_in = acc_next;
            o_len_in = total_ff;
            o_err_in = 1'b0;
            pend_in = '0;
            total_in = '0;
            accum_in = '0;
         end else if (head.entry.last) begin
            emit = 1'b1;
            o_cp_in = '0;
            o_len_in = '0;
            o_err_in = 1'b1;
            pend_in = '0;
            total_in = '0;
            accum_in = '0;
         end else begin
            pend_in = pend_next;
            accum_in = acc_next;
         end
      end
      if (emit) begin
         o_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         o_valid_in = 1'b0;
      end else begin
         o_valid_in = o_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
         total_ff <= '0;
         accum_ff <= '0;
         o_valid_ff <= 1'b0;
      end else begin
         pend_ff <= pend_in;
         total_ff <= total_in;
         accum_ff <= accum_in;
         o_valid_ff <= o_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         o_cp_ff <= o_cp_in;
         o_len_ff <= o_len_in;
         o_err_ff <= o_err_in;
      end
   end

   assign rsp_bus.valid = o_valid_ff;
   assign rsp_bus.code_point = o_cp_ff;
   assign rsp_bus.seq_length = o_len_ff;
   assign rsp_bus.error = o_err_ff;

   `UTF8SD_ASSERT(a_pending_in_range, pend_ff != '0 |-> total_ff >= LEN_W'(2) && pend_ff < total_ff, "pending count outside the sequence length")
   `UTF8SD_ASSERT(a_ascii_result, $past(pop) && $past(pend_ff) == '0 && $past(head.entry.kind) == KIND_ASCII |-> o_valid_ff && o_len_ff == LEN_ASCII && !o_err_ff, "single byte character did not produce a result")

endmodule

`default_nettype wire

FILE: bench/utf8_decode_checker.sv
`timescale 1ns / 100ps
// Scoreboard for the UTF-8 stream decoder: watches both channels, decodes each
// accepted byte itself and compares every result with the oldest expected one.
// Depends on utf8sd_pkg and on the utf8sd_req_if and utf8sd_rsp_if interfaces.

module utf8_decode_checker
   import utf8sd_pkg::*;
(
   input  logic  clock,
   input  logic  reset,
   utf8sd_req_if req_mon,
   utf8sd_rsp_if rsp_mon,
   output int    fail_count,
   output int    chars_awaited
);

   localparam logic [BYTE_W-1:0] CONT_FIRST  = 8'h80;
   localparam logic [BYTE_W-1:0] CONT_LAST   = 8'hBF;
   localparam logic [BYTE_W-1:0] LEAD2_FIRST = 8'hC0;
   localparam logic [BYTE_W-1:0] LEAD3_FIRST = 8'hE0;
   localparam logic [BYTE_W-1:0] LEAD4_FIRST = 8'hF0;
   localparam logic [BYTE_W-1:0] LEAD5_FIRST = 8'hF8;
   localparam logic [BYTE_W-1:0] LEAD6_FIRST = 8'hFC;
   localparam logic [BYTE_W-1:0] LEAD_BAD    = 8'hFE;
   localparam int                REPORT_MAX  = 10;

   typedef struct packed {
      logic [CP_W-1:0]  code_point;
      logic [LEN_W-1:0] seq_length;
      logic             error;
   } decoded_char_t;

   decoded_char_t    expected_chars[$];
   logic [LEN_W-1:0] bytes_owed;
   logic [LEN_W-1:0] char_length;
   logic [CP_W-1:0]  partial_cp;

   function automatic decoded_char_t malformed();
      bytes_owed  = '0;
      char_length = '0;
      partial_cp  = '0;
      return '{code_point: '0, seq_length: '0, error: 1'b1};
   endfunction

   function automatic bit decode_byte(input logic [BYTE_W-1:0] b, input logic eot,
                                      output decoded_char_t res);
      logic [LEN_W-1:0] len;
      logic [6:0]       lead_bits;
      res = '0;
      if (bytes_owed == '0) begin
         if (b < CONT_FIRST) begin
            res.code_point = CP_W'(b);
            res.seq_length = LEN_ASCII;
            return 1'b1;
         end
         if (b < LEAD2_FIRST || b >= LEAD_BAD) begin
            res = malformed();
            return 1'b1;
         end
         if (b < LEAD3_FIRST) begin
            len = 3'd2;
            lead_bits = 7'(b & 8'h1F);
         end else if (b < LEAD4_FIRST) begin
            len = 3'd3;
            lead_bits = 7'(b & 8'h0F);
         end else if (b < LEAD5_FIRST) begin
            len = 3'd4;
            lead_bits = 7'(b & 8'h07);
         end else if (b < LEAD6_FIRST) begin
            len = 3'd5;
            lead_bits = 7'(b & 8'h03);
         end else begin
            len = 3'd6;
            lead_bits = 7'(b & 8'h01);
         end
         if (eot) begin
            res = malformed();
            return 1'b1;
         end
         bytes_owed  = len - 3'd1;
         char_length = len;
         partial_cp  = CP_W'(lead_bits);
         return 1'b0;
      end
      if (b < CONT_FIRST || b > CONT_LAST) begin
         res = malformed();
         return 1'b1;
      end
      partial_cp = {partial_cp[CP_W-7:0], b[5:0]};
      bytes_owed = bytes_owed - 3'd1;
      if (bytes_owed == '0) begin
         res.code_point = partial_cp;
         res.seq_length = char_length;
         char_length = '0;
         partial_cp  = '0;
         return 1'b1;
      end
      if (eot) begin
         res = malformed();
         return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic void note_failure(input string what);
      fail_count++;
      if (fail_count <= REPORT_MAX)
         $display("%0t: %s", $realtime, what);
   endfunction

   always @(posedge clock) begin
      decoded_char_t got;
      decoded_char_t want;
      if (reset) begin
         expected_chars.delete();
         bytes_owed  = '0;
         char_length = '0;
         partial_cp  = '0;
         fail_count  = 0;
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            got = '{rsp_mon.code_point, rsp_mon.seq_length, rsp_mon.error};
            if (expected_chars.size() == 0) begin
               note_failure($sformatf("unexpected result: cp=%h len=%0d err=%b",
                                      got.code_point, got.seq_length, got.error));
            end else begin
               want = expected_chars.pop_front();
               if (got.code_point !== want.code_point || got.seq_length !== want.seq_length
                   || got.error !== want.error)
                  note_failure($sformatf(
                     "mismatch: expected cp=%h len=%0d err=%b, got cp=%h len=%0d err=%b",
                     want.code_point, want.seq_length, want.error,
                     got.code_point, got.seq_length, got.error));
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            if (decode_byte(req_mon.byte_in, req_mon.end_of_text, want))
               expected_chars.push_back(want);
         end
      end
      chars_awaited <= expected_chars.size();
   end

endmodule

FILE: bench/utf8_stream_decoder_unit_tb.sv
`timescale 1ns / 100ps
// Top of the UTF-8 stream decoder testbench: clock, reset, byte stimulus with
// random idling on both channels, a watchdog and the final verdict.
// Depends on utf8sd_pkg, both channel interfaces, utf8_stream_decoder_unit and utf8_decode_checker.

module utf8_stream_decoder_unit_tb;
   import utf8sd_pkg::*;

   localparam int QUIET_LIMIT  = 5000;
   localparam int DRAIN_CYCLES = 8;
   localparam int PHASE_ITEMS  = 285;

   localparam logic [BYTE_W-1:0] ASCII_LAST  = 8'h7F;
   localparam logic [BYTE_W-1:0] CONT_FIRST  = 8'h80;
   localparam logic [BYTE_W-1:0] LEAD2_FIRST = 8'hC0;
   localparam logic [BYTE_W-1:0] LEAD3_FIRST = 8'hE0;
   localparam logic [BYTE_W-1:0] LEAD4_FIRST = 8'hF0;
   localparam logic [BYTE_W-1:0] LEAD5_FIRST = 8'hF8;
   localparam logic [BYTE_W-1:0] LEAD6_FIRST = 8'hFC;
   localparam logic [BYTE_W-1:0] LEAD6_LAST  = 8'hFD;
   localparam logic [BYTE_W-1:0] FOREIGN_HOP = 8'h40;

   // Each entry holds the end-of-text flag above the byte.
   localparam logic [8:0] DIRECTED_BYTES [24] = '{
      9'h000, 9'h17F, 9'h080, 9'h0BF, 9'h0FE, 9'h0FF,
      9'h0DF, 9'h1BF,
      9'h0FD, 9'h0BF, 9'h0BF, 9'h0BF, 9'h0BF, 9'h1BF,
      9'h0E2, 9'h041,
      9'h1C2,
      9'h0F0, 9'h190,
      9'h0F8, 9'h080, 9'h080, 9'h080, 9'h180
   };

   logic clock;
   logic reset;
   int   sender_idle_pct;
   int   receiver_stall_pct;
   int   fail_count;
   int   chars_awaited;
   int   quiet_cycles;
   int   bytes_sent;

   utf8sd_req_if req_bus();
   utf8sd_rsp_if rsp_bus();

   utf8_stream_decoder_unit dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   utf8_decode_checker char_check (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_bus),
      .rsp_mon       (rsp_bus),
      .fail_count    (fail_count),
      .chars_awaited (chars_awaited)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         rsp_bus.ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("watchdog: no request or result accepted for %0d cycles", QUIET_LIMIT);
         $display("** utf8_stream_decoder_unit: FAILED **");
         $finish;
      end
   end

   task automatic send_byte(input logic [BYTE_W-1:0] b, input logic eot);
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid       <= 1'b1;
      req_bus.byte_in     <= b;
      req_bus.end_of_text <= eot;
      do @(posedge clock); while (!req_bus.ready);
      bytes_sent++;
   endtask

   function automatic logic [BYTE_W-1:0] random_lead(input int len);
      case (len)
         1:       return BYTE_W'($urandom_range(0, ASCII_LAST));
         2:       return BYTE_W'($urandom_range(LEAD2_FIRST, LEAD3_FIRST - 1));
         3:       return BYTE_W'($urandom_range(LEAD3_FIRST, LEAD4_FIRST - 1));
         4:       return BYTE_W'($urandom_range(LEAD4_FIRST, LEAD5_FIRST - 1));
         5:       return BYTE_W'($urandom_range(LEAD5_FIRST, LEAD6_FIRST - 1));
         default: return BYTE_W'($urandom_range(LEAD6_FIRST, LEAD6_LAST));
      endcase
   endfunction

   function automatic logic [BYTE_W-1:0] random_cont();
      return CONT_FIRST | BYTE_W'($urandom_range(0, 63));
   endfunction

   // Mostly well-formed characters; the rest is raw noise or sequences that
   // are cut short by a foreign byte or by the end of the text.
   task automatic send_random_char();
      int                roll;
      int                len;
      int                cut;
      bit                eot_break;
      logic [BYTE_W-1:0] foreign;
      roll = $urandom_range(0, 99);
      if (roll < 12) begin
         send_byte(BYTE_W'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
      end else if (roll < 84) begin
         len = $urandom_range(1, 6);
         eot_break = ($urandom_range(0, 9) == 0);
         send_byte(random_lead(len), eot_break && len == 1);
         for (int i = 1; i < len; i++)
            send_byte(random_cont(), eot_break && i == len - 1);
      end else begin
         len = $urandom_range(2, 6);
         cut = $urandom_range(1, len - 1);
         eot_break = ($urandom_range(0, 1) == 1);
         send_byte(random_lead(len), eot_break && cut == 1);
         for (int i = 1; i < cut; i++)
            send_byte(random_cont(), eot_break && i == cut - 1);
         if (!eot_break) begin
            foreign = BYTE_W'($urandom_range(0, 191));
            if (foreign > ASCII_LAST)
               foreign = foreign + FOREIGN_HOP;
            send_byte(foreign, $urandom_range(0, 7) == 0);
         end
      end
   endtask

   initial begin
      reset               <= 1'b1;
      req_bus.valid       <= 1'b0;
      req_bus.byte_in     <= '0;
      req_bus.end_of_text <= 1'b0;
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      foreach (DIRECTED_BYTES[i])
         send_byte(DIRECTED_BYTES[i][7:0], DIRECTED_BYTES[i][8]);

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin
               sender_idle_pct    = 0;
               receiver_stall_pct = 0;
            end
            1: begin
               sender_idle_pct    = 54;
               receiver_stall_pct = 0;
            end
            2: begin
               sender_idle_pct    = 0;
               receiver_stall_pct = 54;
            end
            default: begin
               sender_idle_pct    = 21;
               receiver_stall_pct = 21;
            end
         endcase
         bytes_sent = 0;
         while (bytes_sent < PHASE_ITEMS)
            send_random_char();
      end

      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (chars_awaited != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (fail_count == 0)
         $display("** utf8_stream_decoder_unit: PASSED **");
      else
         $display("** utf8_stream_decoder_unit: FAILED **");
      $finish;
   end

endmodule
